// ===== rtl/core/hav_pkg.sv =====
// ----------------------------------------------------------------------------
// hav_pkg
// Shared constants for the haversine distance pipeline: cordic arctangent
// table, cordic gain, fixed-point scale factors.
// ----------------------------------------------------------------------------
`default_nettype none

package hav_pkg;

    localparam int CORDIC_STEPS = 30;
    localparam int SQRT_STEPS   = 31;
    localparam int TERM_STAGES  = 4;
    localparam int PHASE_STAGES = 6;

    // cordic start value, Q30, compensates the rotation gain
    localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

    // atan(2^-i) in units of 2^-32 turn
    localparam logic [31:0] ATAN_TURNS [0:CORDIC_STEPS-1] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1
    };

    // one in Q60
    localparam logic signed [63:0] ONE_Q60 = 64'sd1 <<< 60;

    // round(4*pi*6371000*64), split so each product stays narrow
    localparam logic [32:0] RADIUS_4PI_Q6 = 33'd5123862220;
    localparam int          K_LO_BITS     = 17;
    localparam logic [K_LO_BITS-1:0] K_LO = RADIUS_4PI_Q6[K_LO_BITS-1:0];
    localparam logic [32-K_LO_BITS:0] K_HI = RADIUS_4PI_Q6[32:K_LO_BITS];

    // degree divisors are 45 times a power of two; x/45 = (x * RECIP_45) >> 38,
    // exact for any 32-bit x
    localparam int          ODD_DIV     = 45;
    localparam int          RECIP_SHIFT = 38;
    localparam logic [32:0] RECIP_45    = 33'd6108397933;
    localparam int          R45_LO_BITS = 17;
    localparam logic [R45_LO_BITS-1:0] R45_LO = RECIP_45[R45_LO_BITS-1:0];
    localparam logic [32-R45_LO_BITS:0] R45_HI = RECIP_45[32:R45_LO_BITS];

endpackage

`default_nettype wire

// ===== rtl/core/hav_phase.sv =====
// ----------------------------------------------------------------------------
// hav_phase
// Converts a signed angle in fixed-point degrees to a 32-bit phase
// (2^-32 turn), rounded half up on the magnitude, via a reciprocal multiply.
// ----------------------------------------------------------------------------
`default_nettype none

module hav_phase import hav_pkg::*; #(
    parameter int FRAC_BITS = 22,
    parameter int DIVISOR   = 360
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [31:0] i_angle,
    output logic        [31:0] o_phase
);

    // divisor is 45 * 2^DSH; the power of two folds into the shift
    localparam int SH  = 32 - FRAC_BITS;
    localparam int DSH = $clog2(DIVISOR / ODD_DIV);
    localparam int RW  = $clog2(ODD_DIV);
    localparam int QW  = 65 - RECIP_SHIFT;
    localparam logic [31:0] ODD_DIV_W = 32'(ODD_DIV);

    logic [31:0]                 w_tab [0:ODD_DIV-1];

    logic [31:0]                 r_mag0;
    logic                        r_neg0;
    logic [32+R45_LO_BITS-1:0]   r_plo;
    logic [32+33-R45_LO_BITS-1:0] r_phi;
    logic [31:0]                 r_mag1;
    logic                        r_neg1;
    logic [QW-1:0]               r_quo2;
    logic [31:0]                 r_mag2;
    logic                        r_neg2;
    logic [QW-1:0]               r_quo3;
    logic [RW-1:0]               r_rem3;
    logic                        r_neg3;
    logic [31:0]                 r_pos4;
    logic                        r_neg4;
    logic [31:0]                 r_phase;

    logic [31:0]                 n_mag;
    logic [64:0]                 n_prod;
    logic [31:0]                 n_back;
    logic [31:0]                 n_diff;
    logic [31:0]                 n_pos;

    // rounded phase contribution of the remainder mod 45
    for (genvar b = 0; b < ODD_DIV; b++) begin : g_tab
        localparam longint TV = ((longint'(b) << SH) + longint'(DIVISOR / 2))
                              / longint'(DIVISOR);
        assign w_tab[b] = 32'(TV);
    end

    always_comb begin
        n_mag  = i_angle[31] ? (32'd0 - i_angle) : i_angle;
        n_prod = {r_phi, {R45_LO_BITS{1'b0}}}
               + {{(65 - (32 + R45_LO_BITS)){1'b0}}, r_plo};
        n_back = {{(32 - QW){1'b0}}, r_quo2} * ODD_DIV_W;
        n_diff = r_mag2 - n_back;
        n_pos  = ({{(32 - QW){1'b0}}, r_quo3} << (SH - DSH)) + w_tab[r_rem3];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag0  <= n_mag;
            r_neg0  <= i_angle[31];

            r_plo   <= r_mag0 * R45_LO;
            r_phi   <= r_mag0 * R45_HI;
            r_mag1  <= r_mag0;
            r_neg1  <= r_neg0;

            r_quo2  <= n_prod[64:RECIP_SHIFT];
            r_mag2  <= r_mag1;
            r_neg2  <= r_neg1;

            r_quo3  <= r_quo2;
            r_rem3  <= n_diff[RW-1:0];
            r_neg3  <= r_neg2;

            r_pos4  <= n_pos;
            r_neg4  <= r_neg3;

            r_phase <= r_neg4 ? (32'd0 - r_pos4) : r_pos4;
        end
    end

    assign o_phase = r_phase;

endmodule

`default_nettype wire

// ===== rtl/core/hav_sincos.sv =====
// ----------------------------------------------------------------------------
// hav_sincos
// Rotation cordic: phase in 2^-32 turn to cosine or sine in Q30,
// quadrant folded before the iterations and restored after.
// ----------------------------------------------------------------------------
`default_nettype none

module hav_sincos import hav_pkg::*; #(
    parameter bit SIN_OUT = 1'b0
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic        [31:0] i_phase,
    output logic signed [31:0] o_val
);

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;

    logic signed [32:0] r_x [0:CORDIC_STEPS];
    logic signed [32:0] r_y [0:CORDIC_STEPS];
    logic signed [32:0] r_z [0:CORDIC_STEPS];
    logic        [1:0]  r_q [0:CORDIC_STEPS];
    logic signed [31:0] r_val;

    logic [31:0] n_sum;
    logic [1:0]  n_q;
    logic [31:0] n_z;

    always_comb begin
        n_sum = i_phase + 32'h2000_0000;
        n_q   = n_sum[31:30];
        n_z   = i_phase - {n_q, 30'd0};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= CORDIC_GAIN;
            r_y[0] <= '0;
            r_z[0] <= {n_z[31], n_z};
            r_q[0] <= n_q;
        end
    end

    for (genvar k = 1; k <= CORDIC_STEPS; k++) begin : g_iter
        logic signed [32:0] w_atan;
        assign w_atan = {1'b0, ATAN_TURNS[k-1]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_z[k-1][32]) begin
                    r_x[k] <= r_x[k-1] - (r_y[k-1] >>> (k-1));
                    r_y[k] <= r_y[k-1] + (r_x[k-1] >>> (k-1));
                    r_z[k] <= r_z[k-1] - w_atan;
                end else begin
                    r_x[k] <= r_x[k-1] + (r_y[k-1] >>> (k-1));
                    r_y[k] <= r_y[k-1] - (r_x[k-1] >>> (k-1));
                    r_z[k] <= r_z[k-1] + w_atan;
                end
                r_q[k] <= r_q[k-1];
            end
        end
    end

    logic signed [32:0] w_x;
    logic signed [32:0] w_y;
    logic signed [32:0] n_cos;
    logic signed [32:0] n_sin;

    always_comb begin
        w_x = r_x[CORDIC_STEPS];
        w_y = r_y[CORDIC_STEPS];
        case (r_q[CORDIC_STEPS])
            QUAD_0: begin
                n_cos = w_x;
                n_sin = w_y;
            end
            QUAD_1: begin
                n_cos = -w_y;
                n_sin = w_x;
            end
            QUAD_2: begin
                n_cos = -w_x;
                n_sin = -w_y;
            end
            default: begin
                n_cos = w_y;
                n_sin = -w_x;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_val <= SIN_OUT ? n_sin[31:0] : n_cos[31:0];
        end
    end

    assign o_val = r_val;

endmodule

`default_nettype wire

// ===== rtl/core/hav_term.sv =====
// ----------------------------------------------------------------------------
// hav_term
// Haversine term a = sl^2 + cos1*cos2*sn^2 in Q60, clamped to [0,1],
// at most one multiply per stage in each product chain; also gives 1-a.
// ----------------------------------------------------------------------------
`default_nettype none

module hav_term import hav_pkg::*; (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [31:0] i_cos_a,
    input  logic signed [31:0] i_cos_b,
    input  logic signed [31:0] i_sin_dlat,
    input  logic signed [31:0] i_sin_dlon,
    output logic        [60:0] o_a,
    output logic        [60:0] o_one_minus_a
);

    logic signed [63:0] r_cc;
    logic signed [63:0] r_sq1;
    logic signed [63:0] r_sq2;
    logic signed [63:0] r_sq3;
    logic signed [31:0] r_sn1;
    logic signed [31:0] r_sn2;
    logic signed [63:0] r_t;
    logic signed [63:0] r_u;
    logic        [60:0] r_a;
    logic        [60:0] r_oma;

    logic signed [31:0] w_cc_q30;
    logic signed [31:0] w_t_q30;
    logic signed [63:0] n_sum;
    logic signed [63:0] n_clamp;

    always_comb begin
        w_cc_q30 = r_cc[61:30];
        w_t_q30  = r_t[61:30];
        n_sum    = r_sq3 + r_u;
        if (n_sum[63]) begin
            n_clamp = '0;
        end else if (n_sum > ONE_Q60) begin
            n_clamp = ONE_Q60;
        end else begin
            n_clamp = n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cc  <= i_cos_a * i_cos_b;
            r_sq1 <= i_sin_dlat * i_sin_dlat;
            r_sn1 <= i_sin_dlon;

            r_t   <= w_cc_q30 * r_sn1;
            r_sq2 <= r_sq1;
            r_sn2 <= r_sn1;

            r_u   <= w_t_q30 * r_sn2;
            r_sq3 <= r_sq2;

            r_a   <= n_clamp[60:0];
            r_oma <= ONE_Q60[60:0] - n_clamp[60:0];
        end
    end

    assign o_a           = r_a;
    assign o_one_minus_a = r_oma;

endmodule

`default_nettype wire

// ===== rtl/core/hav_isqrt.sv =====
// ----------------------------------------------------------------------------
// hav_isqrt
// Floor integer square root of a 61-bit value, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module hav_isqrt import hav_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [60:0] i_val,
    output logic [30:0] o_root
);

    logic [61:0] r_n   [0:SQRT_STEPS-1];
    logic [61:0] r_res [0:SQRT_STEPS-1];
    logic [61:0] w_n   [0:SQRT_STEPS-1];
    logic [61:0] w_res [0:SQRT_STEPS-1];

    assign w_n[0]   = {1'b0, i_val};
    assign w_res[0] = '0;

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
        localparam logic [61:0] BIT = 62'd1 << (60 - 2 * k);
        logic [61:0] w_sum;
        if (k > 0) begin : g_src
            assign w_n[k]   = r_n[k-1];
            assign w_res[k] = r_res[k-1];
        end
        assign w_sum = w_res[k] + BIT;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_n[k] >= w_sum) begin
                    r_n[k]   <= w_n[k] - w_sum;
                    r_res[k] <= (w_res[k] >> 1) + BIT;
                end else begin
                    r_n[k]   <= w_n[k];
                    r_res[k] <= w_res[k] >> 1;
                end
            end
        end
    end

    assign o_root = r_res[SQRT_STEPS-1][30:0];

endmodule

`default_nettype wire

// ===== rtl/core/hav_vector.sv =====
// ----------------------------------------------------------------------------
// hav_vector
// Vectoring cordic: angle of (x, y) in 2^-32 turn, clamped to a quarter turn.
// ----------------------------------------------------------------------------
`default_nettype none

module hav_vector import hav_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [30:0] i_x,
    input  logic [30:0] i_y,
    output logic [30:0] o_angle
);

    localparam logic signed [32:0] QUARTER = 33'sd1 <<< 30;

    logic signed [33:0] r_x [0:CORDIC_STEPS-1];
    logic signed [33:0] r_y [0:CORDIC_STEPS-1];
    logic signed [32:0] r_z [0:CORDIC_STEPS-1];
    logic signed [33:0] w_x [0:CORDIC_STEPS-1];
    logic signed [33:0] w_y [0:CORDIC_STEPS-1];
    logic signed [32:0] w_z [0:CORDIC_STEPS-1];
    logic        [30:0] r_angle;

    assign w_x[0] = {3'd0, i_x};
    assign w_y[0] = {3'd0, i_y};
    assign w_z[0] = '0;

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_iter
        logic signed [32:0] w_atan;
        assign w_atan = {1'b0, ATAN_TURNS[k]};
        if (k > 0) begin : g_src
            assign w_x[k] = r_x[k-1];
            assign w_y[k] = r_y[k-1];
            assign w_z[k] = r_z[k-1];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!w_y[k][33]) begin
                    r_x[k] <= w_x[k] + (w_y[k] >>> k);
                    r_y[k] <= w_y[k] - (w_x[k] >>> k);
                    r_z[k] <= w_z[k] + w_atan;
                end else begin
                    r_x[k] <= w_x[k] - (w_y[k] >>> k);
                    r_y[k] <= w_y[k] + (w_x[k] >>> k);
                    r_z[k] <= w_z[k] - w_atan;
                end
            end
        end
    end

    logic signed [32:0] w_zf;
    assign w_zf = r_z[CORDIC_STEPS-1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (w_zf[32]) begin
                r_angle <= '0;
            end else if (w_zf > QUARTER) begin
                r_angle <= QUARTER[30:0];
            end else begin
                r_angle <= w_zf[30:0];
            end
        end
    end

    assign o_angle = r_angle;

endmodule

`default_nettype wire

// ===== rtl/core/haversine_great_circle_distance_top.sv =====
// ----------------------------------------------------------------------------
// haversine_great_circle_distance_top
// Great-circle distance between two points given in fixed-point degrees,
// on a 6371 km sphere, result in meters with DIST_FRAC_BITS fraction bits.
//
// Input channel: i_valid / o_stall with the four coordinates; a beat is taken
// when i_valid is high and o_stall is low. Output channel: o_valid / i_stall
// with o_distance.
// Throughput: one beat per cycle while o_stall is low. The path from accepted
// input to o_valid runs through the reciprocal-multiply phase conversion, the
// two 30-step cordics and the 31-step square roots, all fully unrolled, and
// the haversine term stages.
// The pipeline advances as one: when o_valid is high and i_stall holds it,
// every stage holds and o_stall goes high; nothing is dropped or repeated.
// Reset clears the valid chain only; no beat is in flight afterwards.
// ----------------------------------------------------------------------------
`default_nettype none

module haversine_great_circle_distance_top import hav_pkg::*; #(
    parameter int ANGLE_FRAC_BITS = 22,
    parameter int DIST_FRAC_BITS  = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [29:0] i_lat_a,
    input  logic signed [30:0] i_lon_a,
    input  logic signed [29:0] i_lat_b,
    input  logic signed [30:0] i_lon_b,
    output logic               o_valid,
    input  logic               i_stall,
    output logic        [28:0] o_distance
);

    localparam int PHASE_LAT = PHASE_STAGES;
    localparam int LAT = PHASE_LAT + (CORDIC_STEPS + 2) + TERM_STAGES
                       + SQRT_STEPS + (CORDIC_STEPS + 1) + 2;
    localparam int SH  = 38 - DIST_FRAC_BITS;

    logic w_en;
    logic [LAT-1:0] r_vld;

    assign w_en    = !(r_vld[LAT-1] && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // angles widened to 32 bits; differences are exact
    logic signed [31:0] w_la;
    logic signed [31:0] w_lb;
    logic signed [31:0] w_dlat;
    logic signed [31:0] w_dlon;

    assign w_la   = {{2{i_lat_a[29]}}, i_lat_a};
    assign w_lb   = {{2{i_lat_b[29]}}, i_lat_b};
    assign w_dlat = w_lb - w_la;
    assign w_dlon = {i_lon_b[30], i_lon_b} - {i_lon_a[30], i_lon_a};

    logic [31:0] w_ph_la;
    logic [31:0] w_ph_lb;
    logic [31:0] w_ph_dlat;
    logic [31:0] w_ph_dlon;

    hav_phase #(.FRAC_BITS(ANGLE_FRAC_BITS), .DIVISOR(360)) u_ph_la (
        .i_clk(i_clk), .i_en(w_en), .i_angle(w_la), .o_phase(w_ph_la)
    );
    hav_phase #(.FRAC_BITS(ANGLE_FRAC_BITS), .DIVISOR(360)) u_ph_lb (
        .i_clk(i_clk), .i_en(w_en), .i_angle(w_lb), .o_phase(w_ph_lb)
    );
    hav_phase #(.FRAC_BITS(ANGLE_FRAC_BITS), .DIVISOR(720)) u_ph_dlat (
        .i_clk(i_clk), .i_en(w_en), .i_angle(w_dlat), .o_phase(w_ph_dlat)
    );
    hav_phase #(.FRAC_BITS(ANGLE_FRAC_BITS), .DIVISOR(720)) u_ph_dlon (
        .i_clk(i_clk), .i_en(w_en), .i_angle(w_dlon), .o_phase(w_ph_dlon)
    );

    logic signed [31:0] w_cos_a;
    logic signed [31:0] w_cos_b;
    logic signed [31:0] w_sin_dlat;
    logic signed [31:0] w_sin_dlon;

    hav_sincos #(.SIN_OUT(1'b0)) u_sc_la (
        .i_clk(i_clk), .i_en(w_en), .i_phase(w_ph_la), .o_val(w_cos_a)
    );
    hav_sincos #(.SIN_OUT(1'b0)) u_sc_lb (
        .i_clk(i_clk), .i_en(w_en), .i_phase(w_ph_lb), .o_val(w_cos_b)
    );
    hav_sincos #(.SIN_OUT(1'b1)) u_sc_dlat (
        .i_clk(i_clk), .i_en(w_en), .i_phase(w_ph_dlat), .o_val(w_sin_dlat)
    );
    hav_sincos #(.SIN_OUT(1'b1)) u_sc_dlon (
        .i_clk(i_clk), .i_en(w_en), .i_phase(w_ph_dlon), .o_val(w_sin_dlon)
    );

    logic [60:0] w_a;
    logic [60:0] w_oma;

    hav_term u_term (
        .i_clk         (i_clk),
        .i_en          (w_en),
        .i_cos_a       (w_cos_a),
        .i_cos_b       (w_cos_b),
        .i_sin_dlat    (w_sin_dlat),
        .i_sin_dlon    (w_sin_dlon),
        .o_a           (w_a),
        .o_one_minus_a (w_oma)
    );

    logic [30:0] w_root_a;
    logic [30:0] w_root_oma;

    hav_isqrt u_sqrt_a   (.i_clk(i_clk), .i_en(w_en), .i_val(w_a),   .o_root(w_root_a));
    hav_isqrt u_sqrt_oma (.i_clk(i_clk), .i_en(w_en), .i_val(w_oma), .o_root(w_root_oma));

    logic [30:0] w_angle;

    hav_vector u_vec (
        .i_clk(i_clk), .i_en(w_en), .i_x(w_root_oma), .i_y(w_root_a), .o_angle(w_angle)
    );

    // scale by radius: two narrow partial products, then add and round
    logic [30+K_LO_BITS:0]      r_plo;
    logic [30+33-K_LO_BITS:0]   r_phi;
    logic [28:0]                r_distance;
    logic [66:0]                n_sum;

    always_comb begin
        n_sum = ({{(67 - (31 + 33 - K_LO_BITS)){1'b0}}, r_phi} << K_LO_BITS)
              + {{(67 - (31 + K_LO_BITS)){1'b0}}, r_plo}
              + (67'd1 << (SH - 1));
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_plo      <= w_angle * K_LO;
            r_phi      <= w_angle * K_HI;
            r_distance <= n_sum[SH+28:SH];
        end
    end

    assign o_distance = r_distance;

endmodule

`default_nettype wire

// ===== rtl/core/hav_checker.sv =====
// ----------------------------------------------------------------------------
// hav_checker
// Port-level checks for the haversine distance block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hav_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_stall,
    input  logic        o_valid,
    input  logic        i_stall,
    input  logic [28:0] o_distance
);

    localparam logic [28:0] DIST_MAX = 29'd320241390;

    // input back-pressure only comes from a held output beat
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a held output beat");

    // a held output beat keeps its value
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_distance)))
        else $error("held output beat changed or vanished");

    // distance never exceeds half the circumference
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_distance <= DIST_MAX))
        else $error("distance beyond half circumference");

    // reset empties the pipeline
    a_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_valid)
        else $error("output valid right after reset");

    // an input beat is taken whenever no output beat is waiting
    a_input_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_valid) |-> !o_stall)
        else $error("input stalled with no output beat waiting");

endmodule

bind haversine_great_circle_distance_top hav_checker u_hav_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_stall    (o_stall),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_distance (o_distance)
);

`default_nettype wire
